// ===== rtl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants for the round-robin task scheduler
// Task count, request codes, memory port bundles and the round-robin pick.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int NUM_TASKS = 5;
  localparam int TASK_AW   = $clog2(NUM_TASKS);      // task slot address
  localparam int TASK_CW   = $clog2(NUM_TASKS + 1);  // counter up to NUM_TASKS
  localparam int WORD_W    = 32;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_DELAY  = 2'd1;
  localparam logic [1:0] REQ_SWITCH = 2'd2;
  localparam logic [1:0] REQ_INIT   = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [WORD_W-1:0] delay_ticks;
    logic [WORD_W-1:0] stack_pointer;
    logic [2:0]        slot_index;
  } req_t;

  typedef struct packed {
    logic              switch_pending;
    logic [WORD_W-1:0] next_stack_pointer;
    logic [2:0]        running_task;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [TASK_AW-1:0] addr;
    logic [WORD_W-1:0]  data;
  } mem_wr_t;

  typedef struct packed {
    logic               re;
    logic [TASK_AW-1:0] addr;
  } mem_rd_t;

  // First ready nonzero slot after 'from', wrapping, ending on 'from'; else 0.
  function automatic logic [TASK_AW-1:0] pick_next(logic [NUM_TASKS-1:0] blk,
                                                   logic [TASK_AW-1:0]   from);
    logic [TASK_AW:0]   k;
    logic [TASK_AW-1:0] sel;
    logic               found;
    sel   = '0;
    found = 1'b0;
    for (int n = 1; n <= NUM_TASKS; n++) begin
      k = {1'b0, from} + (TASK_AW+1)'(n);
      if (k >= (TASK_AW+1)'(NUM_TASKS)) begin
        k = k - (TASK_AW+1)'(NUM_TASKS);
      end
      if (!found && (k != '0) && !blk[k[TASK_AW-1:0]]) begin
        sel   = k[TASK_AW-1:0];
        found = 1'b1;
      end
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rrts_ram.sv =====
// ----------------------------------------------------------------------------
// rrts_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
  parameter int DEPTH = 5,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/rrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrts_ctrl: scheduler sequencer
// Holds tick count, running task and blocked flags; drives the wake-tick and
// stack-pointer memories through read-modify-write sequences per request.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     req_valid_i,
  output logic                          req_ready_o,
  input  wire rrts_pkg::req_t           req_i,
  output logic                          res_valid_o,
  input  wire logic                     res_ready_i,
  output rrts_pkg::res_t                res_o,
  output rrts_pkg::mem_wr_t             wk_wr_o,
  output rrts_pkg::mem_rd_t             wk_rd_o,
  input  wire logic [rrts_pkg::WORD_W-1:0] wk_rdata_i,
  output rrts_pkg::mem_wr_t             sp_wr_o,
  output rrts_pkg::mem_rd_t             sp_rd_o,
  input  wire logic [rrts_pkg::WORD_W-1:0] sp_rdata_i
);

  import rrts_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_TICK    = 3'd1;
  localparam logic [2:0] ST_SW_RD   = 3'd2;
  localparam logic [2:0] ST_SW_DATA = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [WORD_W-1:0]    cnt_q, cnt_d;
  logic [TASK_AW-1:0]   cur_q, cur_d;
  logic [NUM_TASKS-1:0] blocked_q, blocked_d;
  logic [TASK_CW-1:0]   idx_q, idx_d;    // next slot to read during tick scan
  logic [TASK_CW-1:0]   pidx_q, pidx_d;  // slot whose wake tick is on rdata
  logic                 pvld_q, pvld_d;
  res_t                 res_q, res_d;
  logic [TASK_AW-1:0]   nxt;
  logic                 accept;
  logic                 idx_in;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;
  assign nxt         = pick_next(blocked_q, cur_q);
  assign idx_in      = (idx_q < TASK_CW'(NUM_TASKS));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    blocked_d = blocked_q;
    idx_d     = idx_q;
    pidx_d    = pidx_q;
    pvld_d    = 1'b0;
    res_d     = res_q;
    wk_wr_o   = '0;
    wk_rd_o   = '0;
    sp_wr_o   = '0;
    sp_rd_o   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d.running_task       = 3'(cur_q);
          res_d.next_stack_pointer = '0;
          res_d.switch_pending     = 1'b0;
          unique case (req_i.req_type)
            REQ_TICK: begin
              cnt_d                = cnt_q + 1'b1;
              idx_d                = TASK_CW'(1);
              res_d.switch_pending = 1'b1;
              state_d              = ST_TICK;
            end
            REQ_DELAY: begin
              if (cur_q != '0) begin
                wk_wr_o.we           = 1'b1;
                wk_wr_o.addr         = cur_q;
                wk_wr_o.data         = cnt_q + req_i.delay_ticks;
                blocked_d[cur_q]     = 1'b1;
                res_d.switch_pending = 1'b1;
              end
              state_d = ST_DONE;
            end
            REQ_SWITCH: begin
              // save the outgoing stack pointer; read-back happens next cycle
              sp_wr_o.we         = 1'b1;
              sp_wr_o.addr       = cur_q;
              sp_wr_o.data       = req_i.stack_pointer;
              cur_d              = nxt;
              res_d.running_task = 3'(nxt);
              state_d            = ST_SW_RD;
            end
            REQ_INIT: begin
              if (int'(req_i.slot_index) < NUM_TASKS) begin
                sp_wr_o.we   = 1'b1;
                sp_wr_o.addr = TASK_AW'(req_i.slot_index);
                sp_wr_o.data = req_i.stack_pointer;
                blocked_d[TASK_AW'(req_i.slot_index)] = 1'b0;
              end
              state_d = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_TICK: begin
        // read slot idx while comparing slot pidx fetched last cycle
        if (idx_in) begin
          wk_rd_o.re   = 1'b1;
          wk_rd_o.addr = idx_q[TASK_AW-1:0];
          idx_d        = idx_q + 1'b1;
          pidx_d       = idx_q;
          pvld_d       = 1'b1;
        end
        if (pvld_q && blocked_q[pidx_q[TASK_AW-1:0]] && (wk_rdata_i == cnt_q)) begin
          blocked_d[pidx_q[TASK_AW-1:0]] = 1'b0;
        end
        if (!idx_in) begin
          state_d = ST_DONE;
        end
      end
      ST_SW_RD: begin
        sp_rd_o.re   = 1'b1;
        sp_rd_o.addr = cur_q;
        state_d      = ST_SW_DATA;
      end
      ST_SW_DATA: begin
        res_d.next_stack_pointer = sp_rdata_i;
        state_d                  = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cur_q     <= TASK_AW'(1);
      blocked_q <= '0;
      idx_q     <= '0;
      pidx_q    <= '0;
      pvld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cur_q     <= cur_d;
      blocked_q <= blocked_d;
      idx_q     <= idx_d;
      pidx_q    <= pidx_d;
      pvld_q    <= pvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

`ifndef NO_ASSERTIONS
  a_idle_never_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !blocked_q[0]) else $error("idle task marked blocked");

  a_cur_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cur_q) < NUM_TASKS) else $error("running index out of range");

  a_scan_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK) |-> (!wk_wr_o.we && !sp_wr_o.we))
    else $error("memory write during tick scan");

  a_done_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_ready_i) |=> (state_q == ST_IDLE))
    else $error("result handoff did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== rtl/round_robin_task_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_top: round-robin task scheduler with tick delay
// Sequencer plus wake-tick and stack-pointer memories and an output register.
// ----------------------------------------------------------------------------
//
// Channel  Dir  tdata (low bit up)                               tuser
// s_axis   in   delay_ticks[31:0] stack_pointer[63:32]           req_type[1:0]
//                slot_index[66:64], zero pad to 72
// m_axis   out  running_task[2:0] next_stack_pointer[34:3]       -
//                switch_pending[35], zero pad to 40
//
// One request at a time. Tick: scans the wake-tick memory, one slot read per
// cycle, then drains the pipelined compare and hands off the result.
// Switch: save, read back the chosen slot's stack pointer, done.
// Delay and init go straight to done. Results go to an output register, so a
// new request is taken while the previous word still waits on m_axis.
// Reset clears the tick count, all blocked flags and makes task 1 running;
// memory contents are not cleared and are valid only once written.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [71:0] s_axis_tdata_i,   // delay_ticks, stack_pointer, slot_index
  input  wire logic [1:0]  s_axis_tuser_i,   // req_type
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [39:0] m_axis_tdata_o    // running_task, next_stack_pointer,
                                             // switch_pending
);

  import rrts_pkg::*;

  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  mem_wr_t           wk_wr;
  mem_rd_t           wk_rd;
  mem_wr_t           sp_wr;
  mem_rd_t           sp_rd;
  logic [WORD_W-1:0] wk_rdata;
  logic [WORD_W-1:0] sp_rdata;

  // output register state
  logic out_vld_q, out_vld_d;
  res_t out_q;

  assign req.req_type      = s_axis_tuser_i;
  assign req.delay_ticks   = s_axis_tdata_i[31:0];
  assign req.stack_pointer = s_axis_tdata_i[63:32];
  assign req.slot_index    = s_axis_tdata_i[66:64];

  rrts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .wk_wr_o     (wk_wr),
    .wk_rd_o     (wk_rd),
    .wk_rdata_i  (wk_rdata),
    .sp_wr_o     (sp_wr),
    .sp_rd_o     (sp_rd),
    .sp_rdata_i  (sp_rdata)
  );

  // wake tick per task
  rrts_ram #(.DEPTH(NUM_TASKS), .WIDTH(WORD_W)) u_wake_ram (
    .clk_i   (clk_i),
    .we_i    (wk_wr.we),
    .waddr_i (wk_wr.addr),
    .wdata_i (wk_wr.data),
    .re_i    (wk_rd.re),
    .raddr_i (wk_rd.addr),
    .rdata_o (wk_rdata)
  );

  // saved stack pointer per task
  rrts_ram #(.DEPTH(NUM_TASKS), .WIDTH(WORD_W)) u_sp_ram (
    .clk_i   (clk_i),
    .we_i    (sp_wr.we),
    .waddr_i (sp_wr.addr),
    .wdata_i (sp_wr.data),
    .re_i    (sp_rd.re),
    .raddr_i (sp_rd.addr),
    .rdata_o (sp_rdata)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !out_vld_q || m_axis_tready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (res_ready) begin
      out_vld_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0, out_q.switch_pending, out_q.next_stack_pointer,
                            out_q.running_task};

endmodule

`default_nettype wire
